@@ design/c3sp_pkg.sv @@
// Package for the 3x3 same-padding convolution block.
// Holds widths, register codes, reset values and the structs shared by the modules.
// No dependencies.
package c3sp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int PLN_W      = 3;
  localparam int PIDX_W     = 2;
  localparam int KROW_W     = 48;
  localparam int COEF_W     = 16;
  localparam int PIX_W      = 8;
  localparam int MAG_W      = 27;
  localparam int FRAC_W     = 11;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int SUM_W      = PROD_W + 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int MAX_PLANES = 4;

  localparam int JOB_DEPTH  = 4;
  localparam int JOB_PTR_W  = $clog2(JOB_DEPTH);
  localparam int RES_DEPTH  = 16;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);

  localparam logic [KROW_W-1:0] KROW_MID_RST = 48'd134217728;
  localparam logic [WID_W-1:0]  WIDTH_RST    = 11'd640;
  localparam logic [HGT_W-1:0]  HEIGHT_RST   = 13'd480;
  localparam logic [PLN_W-1:0]  PLANES_RST   = 3'd1;
  localparam logic [PIX_W-1:0]  WRAP_MOD     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KROW_TOP = 3'd0,
    CFG_KROW_MID = 3'd1,
    CFG_KROW_BOT = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4,
    CFG_PLANES   = 3'd5,
    CFG_WRAP     = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic [PLN_W-1:0] planes;
  } front_cfg_t;

  typedef struct packed {
    logic [2:0][KROW_W-1:0] krow;
    logic                   wrap;
  } back_cfg_t;

  // Window entry i*3+j is row i (0 = top), column j (0 = left).
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic                  mask_top;
    logic                  en_a;
    logic                  left_a;
    logic                  en_b;
    logic                  left_b;
    logic                  last_plane;
    logic                  last_image;
  } job_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             last_of_plane;
    logic             last_of_image;
  } result_t;

endpackage

@@ design/c3sp_if.sv @@
// Stream interfaces for the input words and result words of the convolution block.
// Depends on c3sp_pkg.
interface c3sp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [c3sp_pkg::PIX_W-1:0]    pixel;
  modport source (output valid, command, pixel, input ready);
  modport sink   (input valid, command, pixel, output ready);
endinterface

interface c3sp_out_if;
  logic                          valid;
  logic                          ready;
  logic [c3sp_pkg::MAG_W-1:0]    magnitude;
  logic                          last_of_plane;
  logic                          last_of_image;
  modport source (output valid, magnitude, last_of_plane, last_of_image, input ready);
  modport sink   (input valid, magnitude, last_of_plane, last_of_image, output ready);
endinterface

@@ design/c3sp_front.sv @@
// Front end: position counters, two line stores, 3x3 window, job build.
// Depends on c3sp_pkg.
module c3sp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [c3sp_pkg::PIX_W-1:0]     in_pixel,
  input  c3sp_pkg::front_cfg_t           cfg,
  output c3sp_pkg::job_t                 job,
  output logic                           job_push,
  input  logic                           job_full
);

  logic [c3sp_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [c3sp_pkg::HGT_W-1:0]  row_r, row_nxt;
  logic [c3sp_pkg::PIDX_W-1:0] plane_r, plane_nxt;
  logic                        drain_r, drain_nxt;
  logic [8:0][c3sp_pkg::PIX_W-1:0] win_r, win_nxt;

  logic [c3sp_pkg::PIX_W-1:0] near_mem [c3sp_pkg::MAX_WIDTH];
  logic [c3sp_pkg::PIX_W-1:0] far_mem  [c3sp_pkg::MAX_WIDTH];
  logic [c3sp_pkg::PIX_W-1:0] near_rd_r, far_rd_r;

  logic [c3sp_pkg::COL_W:0]   w_eff;
  logic [c3sp_pkg::HGT_W-1:0] h_eff;
  logic [c3sp_pkg::PLN_W-1:0] p_eff;
  logic acc, is_pix, act, row_end, emit, last_img, wr_en;
  logic [c3sp_pkg::PIX_W-1:0] bot;

  assign in_ready = !job_full;
  assign acc      = in_valid && !job_full;
  assign is_pix   = (c3sp_pkg::cmd_t'(in_command) == c3sp_pkg::CMD_PIXEL);
  // wrong command for the current phase is dropped
  assign act      = acc && (is_pix ? !drain_r : drain_r);
  assign wr_en    = act && is_pix;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = (c3sp_pkg::COL_W+1)'(1);
    end else if (32'(cfg.width) > c3sp_pkg::MAX_WIDTH) begin
      w_eff = (c3sp_pkg::COL_W+1)'(c3sp_pkg::MAX_WIDTH);
    end else begin
      w_eff = (c3sp_pkg::COL_W+1)'(cfg.width);
    end
    h_eff = (cfg.height == '0) ? c3sp_pkg::HGT_W'(1) : cfg.height;
    if (cfg.planes == '0) begin
      p_eff = c3sp_pkg::PLN_W'(1);
    end else if (32'(cfg.planes) > c3sp_pkg::MAX_PLANES) begin
      p_eff = c3sp_pkg::PLN_W'(c3sp_pkg::MAX_PLANES);
    end else begin
      p_eff = cfg.planes;
    end
  end

  assign row_end  = ((c3sp_pkg::COL_W+1)'(col_r) + 1'b1) >= w_eff;
  assign last_img = ((c3sp_pkg::PLN_W)'(plane_r) + 1'b1) >= p_eff;
  assign bot      = is_pix ? in_pixel : '0;
  assign emit     = is_pix ? (row_r != '0) : 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3+0] = win_r[i*3+1];
      win_nxt[i*3+1] = win_r[i*3+2];
    end
    win_nxt[2] = far_rd_r;
    win_nxt[5] = near_rd_r;
    win_nxt[8] = bot;
  end

  always_comb begin
    job.win        = win_nxt;
    job.mask_top   = is_pix ? (row_r == c3sp_pkg::HGT_W'(1)) : (row_r <= c3sp_pkg::HGT_W'(1));
    job.en_a       = emit && (col_r != '0);
    job.left_a     = (col_r == c3sp_pkg::COL_W'(1));
    job.en_b       = emit && row_end;
    job.left_b     = (col_r == '0);
    job.last_plane = !is_pix && row_end;
    job.last_image = !is_pix && row_end && last_img;
  end
  assign job_push = act && (job.en_a || job.en_b);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    drain_nxt = drain_r;
    if (act) begin
      if (row_end) begin
        col_nxt = '0;
        if (is_pix) begin
          row_nxt = row_r + 1'b1;
          if (((c3sp_pkg::HGT_W+1)'(row_r) + 1'b1) >= (c3sp_pkg::HGT_W+1)'(h_eff)) begin
            drain_nxt = 1'b1;
          end
        end else begin
          row_nxt   = '0;
          drain_nxt = 1'b0;
          plane_nxt = last_img ? '0 : plane_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
      drain_r <= 1'b0;
      win_r   <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
      drain_r <= drain_nxt;
      if (act) begin
        win_r <= win_nxt;
      end
    end
  end

  // Line stores: read data always shows the entry at the next column,
  // with a bypass when that entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      far_mem[col_r]  <= near_rd_r;
      near_mem[col_r] <= in_pixel;
    end
    if (wr_en && (col_nxt == col_r)) begin
      far_rd_r  <= near_rd_r;
      near_rd_r <= in_pixel;
    end else begin
      far_rd_r  <= far_mem[col_nxt];
      near_rd_r <= near_mem[col_nxt];
    end
  end

endmodule

@@ design/c3sp_job_fifo.sv @@
// Short job queue between front end and arithmetic back end.
// Depends on c3sp_pkg.
module c3sp_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  c3sp_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output c3sp_pkg::job_t pop_job
);

  c3sp_pkg::job_t mem_r [c3sp_pkg::JOB_DEPTH];
  logic [c3sp_pkg::JOB_PTR_W-1:0] wp_r, rp_r;
  logic [c3sp_pkg::JOB_PTR_W:0]   cnt_r;

  assign full    = (cnt_r == (c3sp_pkg::JOB_PTR_W+1)'(c3sp_pkg::JOB_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (c3sp_pkg::JOB_PTR_W+1)'(push) - (c3sp_pkg::JOB_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

@@ design/c3sp_back.sv @@
// Back end: two convolution lanes (products, sum/abs, wrap) and result queue.
// Depends on c3sp_pkg.
module c3sp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  input  c3sp_pkg::job_t       job,
  output logic                 job_pop,
  input  c3sp_pkg::back_cfg_t  cfg,
  output logic                 res_valid,
  input  logic                 res_ready,
  output c3sp_pkg::result_t    res
);

  localparam int CNT_W = c3sp_pkg::RES_PTR_W + 1;

  logic signed [c3sp_pkg::PROD_W-1:0] prod_a_r [9];
  logic signed [c3sp_pkg::PROD_W-1:0] prod_b_r [9];
  logic signed [c3sp_pkg::PROD_W-1:0] prod_a   [9];
  logic signed [c3sp_pkg::PROD_W-1:0] prod_b   [9];
  logic s1_v_r, s1_a_r, s1_b_r, s1_lp_r, s1_li_r;
  logic s2_v_r, s2_a_r, s2_b_r, s2_lp_r, s2_li_r;
  logic [c3sp_pkg::MAG_W-1:0] mag_a_r, mag_b_r, mag_a_nxt, mag_b_nxt;
  logic [c3sp_pkg::MAG_W-1:0] out_a, out_b;

  c3sp_pkg::result_t fifo_r [c3sp_pkg::RES_DEPTH];
  logic [c3sp_pkg::RES_PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r, resv_r;
  logic out_hs, wr_a, wr_b;

  // Slots are reserved at pop, so the pipeline never has to stall.
  assign job_pop = job_valid && (resv_r <= CNT_W'(c3sp_pkg::RES_DEPTH - 2));
  assign out_hs  = res_valid && res_ready;

  function automatic logic [c3sp_pkg::MAG_W-1:0] wrap255(input logic [c3sp_pkg::MAG_W-1:0] m);
    logic [15:0] hi;
    logic [8:0]  s1;
    logic [8:0]  s2;
    logic [7:0]  r;
    hi = m[c3sp_pkg::MAG_W-1:c3sp_pkg::FRAC_W];
    s1 = {1'b0, hi[15:8]} + {1'b0, hi[7:0]};
    s2 = 9'(s1[8]) + {1'b0, s1[7:0]};
    r  = (s2 >= 9'(c3sp_pkg::WRAP_MOD)) ? 8'(s2 - 9'(c3sp_pkg::WRAP_MOD)) : s2[7:0];
    return c3sp_pkg::MAG_W'({r, m[c3sp_pkg::FRAC_W-1:0]});
  endfunction

  // Stage 1: masked products. Lane a uses the window as is, lane b the
  // window moved one column left with zero on the right.
  always_comb begin
    logic [c3sp_pkg::PIX_W-1:0] pa, pb;
    logic [c3sp_pkg::COEF_W-1:0] cf;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cf = cfg.krow[i][c3sp_pkg::COEF_W*j +: c3sp_pkg::COEF_W];
        pa = job.win[i*3+j];
        pb = (j < 2) ? job.win[i*3+j+1] : '0;
        if ((i == 0) && job.mask_top) begin
          pa = '0;
          pb = '0;
        end
        if ((j == 0) && job.left_a) begin
          pa = '0;
        end
        if ((j == 0) && job.left_b) begin
          pb = '0;
        end
        prod_a[i*3+j] = $signed({1'b0, pa}) * $signed(cf);
        prod_b[i*3+j] = $signed({1'b0, pb}) * $signed(cf);
      end
    end
  end

  // Stage 2: adder tree and magnitude.
  always_comb begin
    logic signed [c3sp_pkg::SUM_W-1:0] sa, sb;
    sa = '0;
    sb = '0;
    for (int k = 0; k < 9; k++) begin
      sa = sa + c3sp_pkg::SUM_W'(prod_a_r[k]);
      sb = sb + c3sp_pkg::SUM_W'(prod_b_r[k]);
    end
    mag_a_nxt = c3sp_pkg::MAG_W'(sa[c3sp_pkg::SUM_W-1] ? -sa : sa);
    mag_b_nxt = c3sp_pkg::MAG_W'(sb[c3sp_pkg::SUM_W-1] ? -sb : sb);
  end

  assign out_a = cfg.wrap ? wrap255(mag_a_r) : mag_a_r;
  assign out_b = cfg.wrap ? wrap255(mag_b_r) : mag_b_r;
  assign wr_a  = s2_v_r && s2_a_r;
  assign wr_b  = s2_v_r && s2_b_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      prod_a_r[k] <= prod_a[k];
      prod_b_r[k] <= prod_b[k];
    end
    s1_a_r  <= job.en_a;
    s1_b_r  <= job.en_b;
    s1_lp_r <= job.last_plane;
    s1_li_r <= job.last_image;
    mag_a_r <= mag_a_nxt;
    mag_b_r <= mag_b_nxt;
    s2_a_r  <= s1_a_r;
    s2_b_r  <= s1_b_r;
    s2_lp_r <= s1_lp_r;
    s2_li_r <= s1_li_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      resv_r <= '0;
    end else begin
      s1_v_r <= job_pop;
      s2_v_r <= s1_v_r;
      wp_r   <= wp_r + c3sp_pkg::RES_PTR_W'(wr_a) + c3sp_pkg::RES_PTR_W'(wr_b);
      if (out_hs) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r  <= cnt_r + CNT_W'(wr_a) + CNT_W'(wr_b) - CNT_W'(out_hs);
      resv_r <= resv_r + CNT_W'(job_pop && job.en_a) + CNT_W'(job_pop && job.en_b)
              - CNT_W'(out_hs);
    end
  end

  // Result queue: lane a first, lane b (row end) after it.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      fifo_r[wp_r] <= '{magnitude: out_a, last_of_plane: 1'b0, last_of_image: 1'b0};
    end
    if (wr_b) begin
      fifo_r[wr_a ? wp_r + 1'b1 : wp_r] <=
        '{magnitude: out_b, last_of_plane: s2_lp_r, last_of_image: s2_li_r};
    end
  end

  assign res_valid = (cnt_r != '0);
  assign res       = fifo_r[rp_r];

endmodule

@@ design/conv3x3_same_padding.sv @@
// Top level of the 3x3 same-padding convolution: config registers and
// front end / job queue / back end hookup. Depends on c3sp_pkg, c3sp_if,
// c3sp_front, c3sp_job_fifo, c3sp_back.
//
//  channel | dir | word                                      | handshake
//  --------+-----+-------------------------------------------+-----------
//  in_ch   | in  | command[0], pixel[7:0]                    | valid/ready
//  out_ch  | out | magnitude[26:0], last_of_plane, last_of_image | valid/ready
//  cfg     | in  | cfg_index[2:0], cfg_data[47:0]            | cfg_we only
//
// One input word per clock unless stalled; a word gives zero, one or two results.
// A word's results pass the job queue, product and sum/abs registers and wrap.
// Output drains one word per clock while ready, from a 16-entry result queue;
// row-end pairs are absorbed there; input stalls only when it is reserved full.
// rst_n is synchronous; reset clears counters, queues and loads register defaults.
// Line stores hold garbage after reset; padding masks it in a proper stream.
module conv3x3_same_padding (
  input  logic                               clk,
  input  logic                               rst_n,
  c3sp_in_if.sink                            in_ch,
  c3sp_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [c3sp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3sp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  c3sp_pkg::front_cfg_t fcfg_r;
  c3sp_pkg::back_cfg_t  bcfg_r;
  c3sp_pkg::job_t       job_in, job_out;
  c3sp_pkg::result_t    res;
  logic job_push, job_full, job_pop, job_valid;

  // Register file, write-only: users must write while the block is idle; unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcfg_r.krow[0] <= '0;
      bcfg_r.krow[1] <= c3sp_pkg::KROW_MID_RST;
      bcfg_r.krow[2] <= '0;
      bcfg_r.wrap    <= 1'b0;
      fcfg_r.width   <= c3sp_pkg::WIDTH_RST;
      fcfg_r.height  <= c3sp_pkg::HEIGHT_RST;
      fcfg_r.planes  <= c3sp_pkg::PLANES_RST;
    end else if (cfg_we) begin
      case (c3sp_pkg::cfg_reg_t'(cfg_index))
        c3sp_pkg::CFG_KROW_TOP: begin
          bcfg_r.krow[0] <= cfg_data[c3sp_pkg::KROW_W-1:0];
        end
        c3sp_pkg::CFG_KROW_MID: begin
          bcfg_r.krow[1] <= cfg_data[c3sp_pkg::KROW_W-1:0];
        end
        c3sp_pkg::CFG_KROW_BOT: begin
          bcfg_r.krow[2] <= cfg_data[c3sp_pkg::KROW_W-1:0];
        end
        c3sp_pkg::CFG_WIDTH: begin
          fcfg_r.width <= cfg_data[c3sp_pkg::WID_W-1:0];
        end
        c3sp_pkg::CFG_HEIGHT: begin
          fcfg_r.height <= cfg_data[c3sp_pkg::HGT_W-1:0];
        end
        c3sp_pkg::CFG_PLANES: begin
          fcfg_r.planes <= cfg_data[c3sp_pkg::PLN_W-1:0];
        end
        c3sp_pkg::CFG_WRAP: begin
          bcfg_r.wrap <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front: walks the raster, keeps line stores and window, builds jobs.
  c3sp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .in_pixel   (in_ch.pixel),
    .cfg        (fcfg_r),
    .job        (job_in),
    .job_push   (job_push),
    .job_full   (job_full)
  );

  c3sp_job_fifo u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .full     (job_full),
    .pop      (job_pop),
    .valid    (job_valid),
    .pop_job  (job_out)
  );

  // Back: both lanes computed per job, results queued in order.
  c3sp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .cfg       (bcfg_r),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.magnitude     = res.magnitude;
  assign out_ch.last_of_plane = res.last_of_plane;
  assign out_ch.last_of_image = res.last_of_image;

endmodule

@@ design/c3sp_checker.sv @@
// Port-level checks for conv3x3_same_padding, attached with bind.
// Depends on c3sp_pkg and the top level's ports.
module c3sp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [c3sp_pkg::MAG_W-1:0]   out_magnitude,
  input logic                         out_last_of_plane,
  input logic                         out_last_of_image
);

  localparam logic [c3sp_pkg::MAG_W-1:0] MAG_PEAK = 27'd75202560;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude)
      && $stable(out_last_of_plane) && $stable(out_last_of_image))
    else $error("result word changed while stalled");

  a_image_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_image |-> out_last_of_plane)
    else $error("last_of_image without last_of_plane");

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_magnitude <= MAG_PEAK)
    else $error("magnitude beyond largest 3x3 sum");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind conv3x3_same_padding c3sp_checker u_c3sp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_magnitude     (out_ch.magnitude),
  .out_last_of_plane (out_ch.last_of_plane),
  .out_last_of_image (out_ch.last_of_image)
);
